// ===== sv/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== sv/cth_pkg.sv =====
// Shared types and constants for the Content-Type header tokenizer.
// No dependencies; imported by every tokenizer module.
`timescale 1ns / 1ps
`default_nettype none

package cth_pkg;

  localparam int unsigned MaxHeaderBytesDef = 1024;

  localparam int unsigned KindW  = 3;
  localparam int unsigned StartW = 10;
  localparam int unsigned LenW   = 11;
  localparam int unsigned FaultW = 3;
  localparam int unsigned SlotN  = 3;

  // Token kinds
  localparam logic [KindW-1:0] KIND_TYPE    = 3'd0;
  localparam logic [KindW-1:0] KIND_SUBTYPE = 3'd1;
  localparam logic [KindW-1:0] KIND_KEY     = 3'd2;
  localparam logic [KindW-1:0] KIND_VALUE   = 3'd3;
  localparam logic [KindW-1:0] KIND_END     = 3'd4;
  localparam logic [KindW-1:0] KIND_ERROR   = 3'd5;

  // Fault codes
  localparam logic [FaultW-1:0] FAULT_NONE      = 3'd0;
  localparam logic [FaultW-1:0] FAULT_SPACE     = 3'd1;
  localparam logic [FaultW-1:0] FAULT_NO_SLASH  = 3'd2;
  localparam logic [FaultW-1:0] FAULT_NO_EQUALS = 3'd3;
  localparam logic [FaultW-1:0] FAULT_BAD_QUOTE = 3'd4;
  localparam logic [FaultW-1:0] FAULT_TOO_LONG  = 3'd5;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_header;
  } hdr_t;

  typedef struct packed {
    logic [KindW-1:0]  token_kind;
    logic [StartW-1:0] token_start;
    logic [LenW-1:0]   token_length;
    logic [FaultW-1:0] fault_code;
    logic              run_last;
  } tok_t;

  // One result without its end-of-group mark
  typedef struct packed {
    logic [KindW-1:0]  token_kind;
    logic [StartW-1:0] token_start;
    logic [LenW-1:0]   token_length;
    logic [FaultW-1:0] fault_code;
  } slot_t;

  // All results caused by one header byte
  typedef struct packed {
    slot_t [SlotN-1:0] slot;
    logic  [1:0]       count;
  } grp_t;

endpackage

`default_nettype wire

// ===== sv/cth_step.sv =====
// Parser state and per-byte step logic of the tokenizer.
// Depends on cth_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cth_step import cth_pkg::*; #(
  parameter int unsigned MAX_HEADER_BYTES = MaxHeaderBytesDef
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  hdr_t item,
  output grp_t grp
);

  localparam int unsigned PW = $clog2(MAX_HEADER_BYTES + 1);
  localparam logic [PW-1:0] MaxPos  = PW'(MAX_HEADER_BYTES);
  localparam logic [PW-1:0] LastPos = PW'(MAX_HEADER_BYTES - 1);

  localparam logic [2:0] PH_TYPE  = 3'd0;
  localparam logic [2:0] PH_GAP   = 3'd1;
  localparam logic [2:0] PH_KEY   = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  logic [2:0]    phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] slash_off, slash_off_next;
  logic          slash_found, slash_found_next;
  logic [PW-1:0] key_start, key_start_next;
  logic [PW-1:0] eq_off, eq_off_next;
  logic          voq, voq_next;
  logic          pwq, pwq_next;
  logic          error_latched, error_latched_next;

  logic [7:0]        b;
  logic              last, nz, is_q, active;
  logic [2:0]        ph_mid, ph_s2;
  logic [FaultW-1:0] f_pre, fault;
  logic              close1, close2, close_any, cl_type, cl_ok;
  logic              s1_ok, end_do, emit_end;
  logic [PW-1:0]     pos_inc, pos_mid, cl_end, err_at;
  logic [PW-1:0]     vstart, vlen, vstart_adj, vlen_adj;
  slot_t             c0, c1, endtok;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == 8'd32) || (ch inside {[8'd9:8'd13]});
  endfunction

  always_comb begin
    b      = item.data_byte;
    last   = item.end_of_header;
    nz     = (b != CH_NUL);
    is_q   = (b == CH_QUOTE);
    active = (phase != PH_DRAIN);

    slash_found_next = slash_found;
    slash_off_next   = slash_off;
    key_start_next   = key_start;
    eq_off_next      = eq_off;
    voq_next         = voq;
    pwq_next         = pwq;
    ph_mid           = phase;
    f_pre            = FAULT_NONE;
    close1           = 1'b0;

    // Byte stage: classify one nonzero header byte
    if (active && nz) begin
      if (pos >= MaxPos) begin
        f_pre = FAULT_TOO_LONG;
      end else begin
        case (phase)
          PH_TYPE: begin
            if (b == CH_SEMI) begin
              close1 = 1'b1;
            end else if (is_ws(b)) begin
              f_pre = FAULT_SPACE;
            end else if (b == CH_SLASH && !slash_found) begin
              slash_found_next = 1'b1;
              slash_off_next   = pos;
            end
          end
          PH_GAP: begin
            if (b == CH_SEMI) begin
              f_pre = FAULT_NO_EQUALS;
            end else if (b == CH_EQUALS) begin
              key_start_next = pos;
              eq_off_next    = pos;
              voq_next       = 1'b0;
              pwq_next       = 1'b0;
              ph_mid         = PH_VALUE;
            end else if (!is_ws(b)) begin
              key_start_next = pos;
              ph_mid         = PH_KEY;
            end
          end
          PH_KEY: begin
            if (b == CH_SEMI) begin
              f_pre = FAULT_NO_EQUALS;
            end else if (b == CH_EQUALS) begin
              eq_off_next = pos;
              voq_next    = 1'b0;
              pwq_next    = 1'b0;
              ph_mid      = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (b == CH_SEMI) begin
              close1 = 1'b1;
            end else begin
              if (pos == eq_off + PW'(1)) begin
                voq_next = is_q;
              end
              pwq_next = is_q;
            end
          end
          default: begin
          end
        endcase
      end
    end

    pos_inc = pos + PW'(1);

    // Close unit: shared by a ';' in this byte and by the header end
    cl_type = close1 ? (phase == PH_TYPE) : (ph_mid == PH_TYPE);
    cl_end  = close1 ? pos : (nz ? pos_inc : pos);

    c0.token_kind   = KIND_TYPE;
    c0.token_start  = '0;
    c0.token_length = LenW'(slash_off_next);
    c0.fault_code   = FAULT_NONE;
    c1.token_kind   = KIND_SUBTYPE;
    c1.token_start  = StartW'(slash_off_next + PW'(1));
    c1.token_length = LenW'(cl_end - slash_off_next - PW'(1));
    c1.fault_code   = FAULT_NONE;

    vstart     = eq_off_next + PW'(1);
    vlen       = cl_end - vstart;
    vstart_adj = voq_next ? vstart + PW'(1) : vstart;
    vlen_adj   = voq_next ? vlen - PW'(2) : vlen;

    if (cl_type) begin
      cl_ok = slash_found_next;
    end else begin
      cl_ok = !(voq_next && ((vlen < PW'(2)) || !pwq_next));
      c0.token_kind   = KIND_KEY;
      c0.token_start  = StartW'(key_start_next);
      c0.token_length = LenW'(eq_off_next - key_start_next);
      c1.token_kind   = KIND_VALUE;
      c1.token_start  = StartW'(vstart_adj);
      c1.token_length = LenW'(vlen_adj);
    end

    s1_ok   = (f_pre == FAULT_NONE) && !(close1 && !cl_ok);
    pos_mid = (active && nz && s1_ok) ? pos_inc : pos;
    ph_s2   = close1 ? PH_GAP : ph_mid;

    // End stage: zero byte or end flag closes the open segment
    end_do    = active && s1_ok && (!nz || last);
    close2    = end_do && (ph_s2 == PH_TYPE || ph_s2 == PH_VALUE);
    close_any = close1 || close2;

    if (f_pre != FAULT_NONE) begin
      fault = f_pre;
    end else if (close_any && !cl_ok) begin
      fault = cl_type ? FAULT_NO_SLASH : FAULT_BAD_QUOTE;
    end else if (end_do && ph_s2 == PH_KEY) begin
      fault = FAULT_NO_EQUALS;
    end else begin
      fault = FAULT_NONE;
    end
    emit_end = end_do && (fault == FAULT_NONE);

    err_at = (pos_mid > LastPos) ? LastPos : pos_mid;

    endtok.token_kind   = KIND_END;
    endtok.token_start  = '0;
    endtok.token_length = LenW'(pos_mid);
    endtok.fault_code   = FAULT_NONE;

    // Assemble the result group
    grp = '0;
    if (active) begin
      if (fault != FAULT_NONE) begin
        grp.slot[0].token_kind   = KIND_ERROR;
        grp.slot[0].token_start  = StartW'(err_at);
        grp.slot[0].token_length = '0;
        grp.slot[0].fault_code   = fault;
        grp.count                = 2'd1;
      end else if (close_any) begin
        grp.slot[0] = c0;
        grp.slot[1] = c1;
        grp.slot[2] = endtok;
        grp.count   = emit_end ? 2'd3 : 2'd2;
      end else if (emit_end) begin
        grp.slot[0] = endtok;
        grp.count   = 2'd1;
      end
    end

    // Next state
    pos_next           = pos_mid;
    error_latched_next = error_latched;
    phase_next         = ph_mid;
    if (close_any && cl_ok) begin
      phase_next = PH_GAP;
    end
    if (emit_end || fault != FAULT_NONE) begin
      phase_next = PH_DRAIN;
    end
    if (fault != FAULT_NONE) begin
      error_latched_next = 1'b1;
    end

    // Final byte of a finished header: start over
    if (phase_next == PH_DRAIN && last) begin
      phase_next         = PH_TYPE;
      pos_next           = '0;
      slash_off_next     = '0;
      slash_found_next   = 1'b0;
      key_start_next     = '0;
      eq_off_next        = '0;
      voq_next           = 1'b0;
      pwq_next           = 1'b0;
      error_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TYPE;
      pos           <= '0;
      slash_off     <= '0;
      slash_found   <= 1'b0;
      key_start     <= '0;
      eq_off        <= '0;
      voq           <= 1'b0;
      pwq           <= 1'b0;
      error_latched <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      pos           <= pos_next;
      slash_off     <= slash_off_next;
      slash_found   <= slash_found_next;
      key_start     <= key_start_next;
      eq_off        <= eq_off_next;
      voq           <= voq_next;
      pwq           <= pwq_next;
      error_latched <= error_latched_next;
    end
  end

  `ASSERT_NOW(step_err_drains, clk, rst, error_latched, phase == PH_DRAIN)
  `ASSERT_NOW(step_pos_bound, clk, rst, phase != PH_DRAIN, pos <= MaxPos)

endmodule

`default_nettype wire

// ===== sv/cth_serial.sv =====
// Result register: holds one byte's token group and hands it out one token a cycle while tok_ready is high.
// Depends on cth_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cth_serial import cth_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  grp_t grp,
  output logic load_ok,
  output logic tok_valid,
  input  logic tok_ready,
  output tok_t tok
);

  slot_t [SlotN-1:0] slot;
  logic  [1:0]       cnt;
  logic  [1:0]       idx;
  logic              last_slot;
  slot_t             cur;

  assign last_slot = (idx == cnt - 2'd1);
  assign tok_valid = (cnt != 2'd0);
  assign load_ok   = (cnt == 2'd0) || (tok_ready && last_slot);
  assign cur       = slot[idx];

  always_comb begin
    tok.token_kind   = cur.token_kind;
    tok.token_start  = cur.token_start;
    tok.token_length = cur.token_length;
    tok.fault_code   = cur.fault_code;
    tok.run_last     = last_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= grp.count;
      idx <= 2'd0;
    end else if (tok_valid && tok_ready) begin
      if (last_slot) begin
        cnt <= 2'd0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= grp.slot;
    end
  end

  `ASSERT_NOW(ser_idx_in_range, clk, rst, cnt != 2'd0, idx < cnt)
  `ASSERT_NEXT(ser_group_continues, clk, rst, tok_valid && tok_ready && !last_slot, tok_valid)

endmodule

`default_nettype wire

// ===== sv/content_type_header_tokenizer.sv =====
// Content-Type header tokenizer top level; uses cth_pkg, cth_step and cth_serial.
// Path: an accepted byte waits in the input register, then its tokens go to the result register.
// Throughput: one byte per cycle while each byte yields at most one token and tok_ready is
//   high; a byte yielding more tokens (up to 3) holds the result register until its last is taken.
// Reset: rst is synchronous, active high; clears the input register, the token
//   group register and the parser state to the start of a new header.
`timescale 1ns / 1ps
`default_nettype none

module content_type_header_tokenizer import cth_pkg::*; #(
  parameter int unsigned MAX_HEADER_BYTES = MaxHeaderBytesDef
) (
  input  logic clk,
  input  logic rst,
  input  logic hdr_valid,
  output logic hdr_ready,
  input  hdr_t hdr,
  output logic tok_valid,
  input  logic tok_ready,
  output tok_t tok
);

  // Input register: one header byte waiting for the step logic
  logic hold_valid;
  hdr_t hold;

  // Step-to-result-register handoff
  logic load;
  logic load_ok;
  grp_t grp;

  // Take a new transaction whenever the input register is empty or the held byte moves on
  // this cycle, so bytes stream in back to back while the result register drains.
  assign hdr_ready = !hold_valid || load_ok;
  assign load      = hold_valid && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hdr_ready) begin
      hold_valid <= hdr_valid;
    end
  end

  // Hold payload only on an accepted transaction
  always_ff @(posedge clk) begin
    if (hdr_valid && hdr_ready) begin
      hold <= hdr;
    end
  end

  // Parser state plus the single-pass step: classify the byte, close
  // segments and build up to three tokens for it.
  cth_step #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_step (
    .clk (clk),
    .rst (rst),
    .fire(load),
    .item(hold),
    .grp (grp)
  );

  // Result register: advance one token per output transaction and mark
  // the last token of each byte's group.
  cth_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp      (grp),
    .load_ok  (load_ok),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok      (tok)
  );

endmodule

`default_nettype wire

// ===== bench/content_type_header_tokenizer_tb.sv =====
// Self-checking bench for content_type_header_tokenizer: header bytes in, tokens out.
// Depends on cth_pkg and the tokenizer RTL; a token tracker class predicts every token.
`timescale 1ns / 1ps

module content_type_header_tokenizer_tb;
  import cth_pkg::*;

  localparam int unsigned HeaderLimit   = MaxHeaderBytesDef;
  localparam int          RxHoldCycles  = 250;
  localparam int          WatchdogLimit = 3000;
  localparam int          RandomBytes   = 150;

  typedef enum logic [2:0] {IN_TYPE, IN_GAP, IN_KEY, IN_VALUE, DRAINING} parse_phase_e;

  // Tracks parser state and holds the tokens the block still owes.
  class token_tracker;
    tok_t         pending_tokens[$];
    tok_t         step_toks[$];
    parse_phase_e phase = IN_TYPE;
    logic [10:0]  byte_pos = '0;
    logic [9:0]   slash_at = '0;
    bit           has_slash = 1'b0;
    logic [9:0]   key_at = '0;
    logic [9:0]   equals_at = '0;
    bit           value_quoted = 1'b0;
    bit           prev_quote = 1'b0;
    int           mismatches = 0;
    int           tokens_seen = 0;
    int           headers_seen = 0;
    logic [7:0]   kinds_seen = '0;
    logic [7:0]   faults_seen = '0;

    function void clear_state();
      phase        = IN_TYPE;
      byte_pos     = '0;
      slash_at     = '0;
      has_slash    = 1'b0;
      key_at       = '0;
      equals_at    = '0;
      value_quoted = 1'b0;
      prev_quote   = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void emit(logic [KindW-1:0] kind, int unsigned start, int unsigned len,
                       logic [FaultW-1:0] fault);
      tok_t t;
      t.token_kind   = kind;
      t.token_start  = start[StartW-1:0];
      t.token_length = len[LenW-1:0];
      t.fault_code   = fault;
      t.run_last     = 1'b0;
      step_toks.push_back(t);
    endfunction

    function logic [FaultW-1:0] close_type(int unsigned end_at);
      if (!has_slash) return FAULT_NO_SLASH;
      emit(KIND_TYPE, 0, slash_at, FAULT_NONE);
      emit(KIND_SUBTYPE, slash_at + 1, end_at - slash_at - 1, FAULT_NONE);
      phase = IN_GAP;
      return FAULT_NONE;
    endfunction

    function logic [FaultW-1:0] close_value(int unsigned end_at);
      int unsigned vstart;
      int unsigned vlen;
      vstart = equals_at + 1;
      vlen   = end_at - vstart;
      if (value_quoted) begin
        if (vlen < 2 || !prev_quote) return FAULT_BAD_QUOTE;
        vstart += 1;
        vlen   -= 2;
      end
      emit(KIND_KEY, key_at, equals_at - key_at, FAULT_NONE);
      emit(KIND_VALUE, vstart, vlen, FAULT_NONE);
      phase = IN_GAP;
      return FAULT_NONE;
    endfunction

    // Advance the parser by one accepted byte; return 1 unless the byte was drained.
    function bit take_byte(hdr_t h);
      int unsigned       pos;
      int unsigned       at;
      logic [FaultW-1:0] fault;
      logic [7:0]        c;
      tok_t              t;
      c     = h.data_byte;
      pos   = byte_pos;
      fault = FAULT_NONE;
      step_toks.delete();
      if (phase == DRAINING) begin
        if (h.end_of_header) clear_state();
        return 1'b0;
      end
      if (c != CH_NUL) begin
        if (pos >= HeaderLimit) begin
          fault = FAULT_TOO_LONG;
        end else begin
          case (phase)
            IN_TYPE: begin
              if (c == CH_SEMI) fault = close_type(pos);
              else if (is_space(c)) fault = FAULT_SPACE;
              else if (c == CH_SLASH && !has_slash) begin
                has_slash = 1'b1;
                slash_at  = pos[9:0];
              end
            end
            IN_GAP: begin
              if (c == CH_SEMI) fault = FAULT_NO_EQUALS;
              else if (c == CH_EQUALS) begin
                key_at       = pos[9:0];
                equals_at    = pos[9:0];
                value_quoted = 1'b0;
                prev_quote   = 1'b0;
                phase        = IN_VALUE;
              end else if (!is_space(c)) begin
                key_at = pos[9:0];
                phase  = IN_KEY;
              end
            end
            IN_KEY: begin
              if (c == CH_SEMI) fault = FAULT_NO_EQUALS;
              else if (c == CH_EQUALS) begin
                equals_at    = pos[9:0];
                value_quoted = 1'b0;
                prev_quote   = 1'b0;
                phase        = IN_VALUE;
              end
            end
            default: begin
              if (c == CH_SEMI) fault = close_value(pos);
              else begin
                if (pos == equals_at + 1) value_quoted = (c == CH_QUOTE);
                prev_quote = (c == CH_QUOTE);
              end
            end
          endcase
        end
        if (fault == FAULT_NONE) begin
          pos      += 1;
          byte_pos  = pos[10:0];
        end
      end
      if (fault == FAULT_NONE && (c == CH_NUL || h.end_of_header)) begin
        case (phase)
          IN_TYPE:  fault = close_type(pos);
          IN_KEY:   fault = FAULT_NO_EQUALS;
          IN_VALUE: fault = close_value(pos);
          default: ;
        endcase
        if (fault == FAULT_NONE) begin
          emit(KIND_END, 0, pos, FAULT_NONE);
          phase = DRAINING;
        end
      end
      if (fault != FAULT_NONE) begin
        at = (pos > HeaderLimit - 1) ? HeaderLimit - 1 : pos;
        emit(KIND_ERROR, at, 0, fault);
        phase = DRAINING;
      end
      if (phase == DRAINING && h.end_of_header) clear_state();
      foreach (step_toks[i]) begin
        t          = step_toks[i];
        t.run_last = (i == step_toks.size() - 1);
        pending_tokens.push_back(t);
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_token(tok_t t);
      tok_t e;
      tokens_seen++;
      kinds_seen[t.token_kind] = 1'b1;
      if (t.token_kind == KIND_ERROR) faults_seen[t.fault_code] = 1'b1;
      if (t.token_kind == KIND_END || t.token_kind == KIND_ERROR) headers_seen++;
      if (pending_tokens.size() == 0) begin
        $error("token with nothing pending: kind %0d start %0d length %0d",
               t.token_kind, t.token_start, t.token_length);
        mismatches++;
        return;
      end
      e = pending_tokens.pop_front();
      compare_field("token_kind", e.token_kind, t.token_kind);
      compare_field("token_start", e.token_start, t.token_start);
      compare_field("token_length", e.token_length, t.token_length);
      compare_field("fault_code", e.fault_code, t.fault_code);
      compare_field("run_last", e.run_last, t.run_last);
    endfunction

    function int tokens_owed();
      return pending_tokens.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hdr_valid = 1'b0;
  logic hdr_ready;
  hdr_t hdr = '0;
  logic tok_valid;
  logic tok_ready = 1'b0;
  tok_t tok;

  token_tracker trk = new;
  int   cycle_n = 0;
  int   sent_n = 0;
  int   live_bytes = 0;
  int   idle_n = 0;
  bit   rx_hold_req = 1'b0;

  content_type_header_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr       (hdr),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Check every token transaction against the oldest pending prediction.
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (!rst && tok_valid && tok_ready) trk.match_token(tok);
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (hdr_valid && hdr_ready) || (tok_valid && tok_ready)) begin
      idle_n <= 0;
    end else if (idle_n >= WatchdogLimit) begin
      $error("timeout: no transaction for %0d cycles, %0d tokens pending",
             idle_n, trk.tokens_owed());
      $display("content_type_header_tokenizer_tb NOT OK");
      $finish;
    end else begin
      idle_n <= idle_n + 1;
    end
  end

  // Receiver: mostly ready, short and long stalls, quiet stretches with no stall,
  // and one long hold-off on request so the block backs up into its input.
  initial begin
    int stall;
    int r;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        tok_ready <= 1'b0;
        repeat (RxHoldCycles - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (stall > 0) begin
        tok_ready <= 1'b0;
        stall--;
      end else begin
        tok_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if ((cycle_n / 200) % 4 == 3) stall = 0;
        else if (r < 65) stall = 0;
        else if (r < 92) stall = $urandom_range(1, 3);
        else stall = $urandom_range(10, 40);
      end
    end
  end

  // Offer one byte; hold valid and payload until the transaction completes.
  task automatic send_byte(input logic [7:0] c, input logic last_flag);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if ((sent_n / 60) % 3 == 2) gap = 0;
    else if (r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    @(negedge clk);
    if (gap > 0) begin
      hdr_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hdr_valid <= 1'b1;
    hdr       <= '{data_byte: c, end_of_header: last_flag};
    do @(posedge clk); while (!hdr_ready);
    sent_n++;
    if (trk.take_byte(hdr)) live_bytes++;
  endtask

  task automatic send_text(input string s, input bit end_flag);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_flag && i == s.len() - 1);
  endtask

  function automatic logic [7:0] plain_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(1, 255));
    if (r < 7) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(48, 57));
  endfunction

  function automatic logic [7:0] space_char();
    if ($urandom_range(0, 1) == 0) return 8'd32;
    return 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 7))
      0: return CH_SEMI;
      1: return CH_SLASH;
      2: return CH_EQUALS;
      3: return CH_QUOTE;
      4: return space_char();
      5: return CH_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a header: mostly well-formed type/subtype plus parameters with random
  // content, some corrupted at one byte, some pure noise; vary how it ends.
  task automatic send_random_header();
    logic [7:0] hq[$];
    int         pos;
    bit         quoted;
    int         mode;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) hq.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 4)) hq.push_back(plain_char());
      hq.push_back(CH_SLASH);
      repeat ($urandom_range(0, 4)) hq.push_back(plain_char());
      repeat ($urandom_range(0, 3)) begin
        hq.push_back(CH_SEMI);
        repeat ($urandom_range(0, 2)) hq.push_back(space_char());
        repeat ($urandom_range(0, 3)) hq.push_back(plain_char());
        hq.push_back(CH_EQUALS);
        quoted = ($urandom_range(0, 2) == 0);
        if (quoted) hq.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 4)) hq.push_back(plain_char());
        if (quoted) hq.push_back(CH_QUOTE);
      end
      if ($urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, hq.size() - 1);
        case ($urandom_range(0, 2))
          0: hq.insert(pos, special_char());
          1: hq.delete(pos);
          default: hq[pos] = special_char();
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) hq.push_back(space_char());
    end
    // Terminate with the last flag alone, a zero byte, or a zero byte plus trailing bytes.
    mode = $urandom_range(0, 5);
    if (mode == 4) begin
      hq.push_back(CH_NUL);
    end else if (mode == 5) begin
      hq.push_back(CH_NUL);
      repeat ($urandom_range(1, 3)) hq.push_back(8'($urandom_range(0, 255)));
    end
    if (hq.size() == 0) hq.push_back(CH_NUL);
    foreach (hq[i]) send_byte(hq[i], i == hq.size() - 1);
  endtask

  initial begin
    int hdr_n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed headers: empty type and subtype with an empty quoted value,
    // space in type, missing slash, bare key at end, lone quote, empty parameter
    // with drained trailing byte, zero byte ending early, trailing whitespace,
    // and an empty header ended by a zero byte.
    send_text("/;=\"\"", 1'b1);
    send_text(" ", 1'b1);
    send_text("x", 1'b1);
    send_text("/; k", 1'b1);
    send_text("/;=\"", 1'b1);
    send_text("/;;", 1'b0);
    send_byte("z", 1'b1);
    send_text("/", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("/; \t", 1'b1);
    send_byte(CH_NUL, 1'b1);

    // Random headers. Midway, hold off the receiver while bytes keep coming,
    // then later let every pending token drain before resuming.
    live_bytes = 0;
    hdr_n = 0;
    while (live_bytes < RandomBytes) begin
      if (hdr_n == 8) rx_hold_req = 1'b1;
      if (hdr_n == 20) begin
        // Drop valid so the last byte is not offered again while draining.
        @(negedge clk);
        hdr_valid <= 1'b0;
        while (trk.tokens_owed() != 0) @(posedge clk);
      end
      send_random_header();
      hdr_n++;
    end

    @(negedge clk);
    hdr_valid <= 1'b0;
    while (trk.tokens_owed() != 0) @(posedge clk);
    // Catch any stray token the block might still emit.
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes; %0d headers closed, %0d tokens compared, %0d mismatches.",
             sent_n, trk.headers_seen, trk.tokens_seen, trk.mismatches);
    $display("Token kinds seen %b, fault codes seen %b.", trk.kinds_seen, trk.faults_seen);
    if (trk.mismatches == 0) begin
      $display("content_type_header_tokenizer_tb OK");
    end else begin
      $display("content_type_header_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
